### hdl/baro_pressure_temperature_compensation_defines.svh
// assertion macros for the barometer compensation block
// used by the top level only, expects clk_i and rst_ni in scope
`ifndef BARO_PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH
`define BARO_PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH
`ifndef SYNTHESIS
`define BPTC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bptc assertion failed");
`define BPTC_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("bptc forbidden condition");
`else
`define BPTC_ASSERT(name, prop)
`define BPTC_ASSERT_NEVER(name, cond)
`endif
`endif

### hdl/bptc_pkg.sv
// shared types and constants for the barometer compensation block
// no dependencies
package bptc_pkg;

  localparam int unsigned RawW  = 24;
  localparam int unsigned CalW  = 16;
  localparam int unsigned RatioW = 8;
  localparam int unsigned OutW  = 32;
  localparam int unsigned MulBW = 25;
  localparam int unsigned WideW = 64;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_C1    = 3'd0,
    CFG_C2    = 3'd1,
    CFG_C3    = 3'd2,
    CFG_C4    = 3'd3,
    CFG_C5    = 3'd4,
    CFG_C6    = 3'd5,
    CFG_RATIO = 3'd6
  } cfg_idx_e;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_CAPTURE,
    OP_MUL_TC,
    OP_MUL_OFF,
    OP_MUL_SENS,
    OP_MUL_DD,
    OP_MUL_F,
    OP_MUL_F2,
    OP_MUL_P,
    OP_WB_T,
    OP_WB_OFF,
    OP_WB_SENS,
    OP_WB_T2,
    OP_WB_F,
    OP_WB_F2,
    OP_WB_P,
    OP_CORR,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic mul_done;
    logic is_p;
    logic t_low;
    logic t_vlow;
    logic out_free;
  } dp_status_t;

endpackage

### hdl/bptc_in_if.sv
// input channel of the barometer compensation block
// depends on bptc_pkg
interface bptc_in_if;
  logic                           valid;
  logic                           ready;
  logic [bptc_pkg::RawW-1:0]      raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink (input valid, input raw_sample, output ready);
endinterface

### hdl/bptc_out_if.sv
// result channel of the barometer compensation block
// depends on bptc_pkg
interface bptc_out_if;
  logic                             valid;
  logic                             ready;
  logic                             is_pressure;
  logic signed [bptc_pkg::OutW-1:0] temperature;
  logic signed [bptc_pkg::OutW-1:0] pressure;
  logic                             next_is_pressure;

  modport source (output valid, output is_pressure, output temperature, output pressure,
                  output next_is_pressure, input ready);
  modport sink (input valid, input is_pressure, input temperature, input pressure,
                input next_is_pressure, output ready);
endinterface

### hdl/baro_pressure_temperature_compensation.sv
// each multiply runs 25 steps on one shared shift-add unit; a pressure word needs
// only the pressure multiply, a temperature word those for temperature, offset and
// sensitivity, dT squared and a first correction below 20 C, a second below -15 C
// throughput: one word at a time, the next is taken on the edge that loads the result
// register; a result held by the receiver stalls the sequencer and so the input
// reset (async, active low) clears calibration, phase, T/OFF/SENS/P; ratio resets to one
module baro_pressure_temperature_compensation (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bptc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bptc_pkg::CalW-1:0]      cfg_data_i,
  bptc_in_if.sink                        in_i,
  bptc_out_if.source                     out_o
);

`include "baro_pressure_temperature_compensation_defines.svh"

  bptc_pkg::dp_cmd_t    cmd;
  bptc_pkg::dp_status_t status;
  logic                 in_ready;
  logic                 in_accept;

  // input word taken only while the sequencer idles
  assign in_i.ready = in_ready;
  assign in_accept  = in_i.valid && in_ready;

  // sequencer walks dT, temperature, offset, sensitivity, corrections or pressure
  bptc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready)
  );

  // datapath holds calibration, stored terms and the result register
  bptc_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_accept_i  (in_accept),
    .raw_i        (in_i.raw_sample),
    .out_ready_i  (out_o.ready),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_o.valid),
    .out_is_p_o   (out_o.is_pressure),
    .out_temp_o   (out_o.temperature),
    .out_press_o  (out_o.pressure),
    .out_next_p_o (out_o.next_is_pressure)
  );

  // result register must be empty when a finished word is written into it
  `BPTC_ASSERT(a_finish_into_empty, (cmd.op == bptc_pkg::OP_FINISH) |-> !out_o.valid)
  // no new word while the multiplier is still working
  `BPTC_ASSERT_NEVER(a_accept_while_busy, in_accept && status.mul_busy)
  // a finished product is always written back on the next cycle
  `BPTC_ASSERT(a_done_writeback, status.mul_done |=> (cmd.op == bptc_pkg::OP_WB_T ||
    cmd.op == bptc_pkg::OP_WB_OFF || cmd.op == bptc_pkg::OP_WB_SENS ||
    cmd.op == bptc_pkg::OP_WB_T2 || cmd.op == bptc_pkg::OP_WB_F ||
    cmd.op == bptc_pkg::OP_WB_F2 || cmd.op == bptc_pkg::OP_WB_P))

endmodule

### hdl/bptc_ctrl.sv
// sequencer for the compensation datapath
// depends on bptc_pkg
module bptc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_accept_i,
  input  bptc_pkg::dp_status_t status_i,
  output bptc_pkg::dp_cmd_t    cmd_o,
  output logic                 in_ready_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_CAPT, S_TC_W, S_OFF, S_OFF_W, S_SENS, S_SENS_W, S_DD, S_DD_W,
    S_F, S_F_W, S_F2, S_F2_W, S_CORR, S_FIN, S_P_W
  } state_e;

  state_e           state_q;
  bptc_pkg::dp_op_e op_q;

  assign cmd_o.op   = op_q;
  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= bptc_pkg::OP_IDLE;
    end else begin
      op_q <= bptc_pkg::OP_IDLE;
      unique case (state_q)
        S_IDLE: begin
          if (in_accept_i) begin
            op_q    <= bptc_pkg::OP_CAPTURE;
            state_q <= S_CAPT;
          end
        end
        S_CAPT: begin
          if (status_i.is_p) begin
            op_q    <= bptc_pkg::OP_MUL_P;
            state_q <= S_P_W;
          end else begin
            op_q    <= bptc_pkg::OP_MUL_TC;
            state_q <= S_TC_W;
          end
        end
        S_TC_W: begin
          if (status_i.mul_done) begin
            op_q    <= bptc_pkg::OP_WB_T;
            state_q <= S_OFF;
          end
        end
        S_OFF: begin
          op_q    <= bptc_pkg::OP_MUL_OFF;
          state_q <= S_OFF_W;
        end
        S_OFF_W: begin
          if (status_i.mul_done) begin
            op_q    <= bptc_pkg::OP_WB_OFF;
            state_q <= S_SENS;
          end
        end
        S_SENS: begin
          op_q    <= bptc_pkg::OP_MUL_SENS;
          state_q <= S_SENS_W;
        end
        S_SENS_W: begin
          if (status_i.mul_done) begin
            op_q    <= bptc_pkg::OP_WB_SENS;
            state_q <= status_i.t_low ? S_DD : S_FIN;
          end
        end
        S_DD: begin
          op_q    <= bptc_pkg::OP_MUL_DD;
          state_q <= S_DD_W;
        end
        S_DD_W: begin
          if (status_i.mul_done) begin
            op_q    <= bptc_pkg::OP_WB_T2;
            state_q <= S_F;
          end
        end
        S_F: begin
          op_q    <= bptc_pkg::OP_MUL_F;
          state_q <= S_F_W;
        end
        S_F_W: begin
          if (status_i.mul_done) begin
            op_q    <= bptc_pkg::OP_WB_F;
            state_q <= status_i.t_vlow ? S_F2 : S_CORR;
          end
        end
        S_F2: begin
          op_q    <= bptc_pkg::OP_MUL_F2;
          state_q <= S_F2_W;
        end
        S_F2_W: begin
          if (status_i.mul_done) begin
            op_q    <= bptc_pkg::OP_WB_F2;
            state_q <= S_CORR;
          end
        end
        S_CORR: begin
          op_q    <= bptc_pkg::OP_CORR;
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (status_i.out_free) begin
            op_q    <= bptc_pkg::OP_FINISH;
            state_q <= S_IDLE;
          end
        end
        S_P_W: begin
          if (status_i.mul_done) begin
            op_q    <= bptc_pkg::OP_WB_P;
            state_q <= S_FIN;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/bptc_dpath.sv
// compensation datapath: calibration registers, shift-add multiplier, terms
// depends on bptc_pkg
module bptc_dpath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [bptc_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [bptc_pkg::CalW-1:0]              cfg_data_i,
  input  logic                                   in_accept_i,
  input  logic [bptc_pkg::RawW-1:0]              raw_i,
  input  logic                                   out_ready_i,
  input  bptc_pkg::dp_cmd_t                      cmd_i,
  output bptc_pkg::dp_status_t                   status_o,
  output logic                                   out_valid_o,
  output logic                                   out_is_p_o,
  output logic signed [bptc_pkg::OutW-1:0]       out_temp_o,
  output logic signed [bptc_pkg::OutW-1:0]       out_press_o,
  output logic                                   out_next_p_o
);

  localparam int unsigned WW = bptc_pkg::WideW;
  localparam int unsigned BW = bptc_pkg::MulBW;
  localparam int unsigned CntW = $clog2(BW);

  logic [bptc_pkg::CalW-1:0]   c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
  logic [bptc_pkg::RatioW-1:0] ratio_q, phase_q, phase_next;

  logic [bptc_pkg::RawW-1:0]   raw_q;
  logic signed [BW-1:0]        dt_q;
  logic signed [bptc_pkg::OutW-1:0] temp_q, t2_q, press_q;
  logic signed [WW-1:0]        off_q, sens_q, off2_q, sens2_q;

  // shift-add multiplier
  logic signed [WW-1:0]        acc_q, ma_q;
  logic [BW-1:0]               mb_q;
  logic [CntW-1:0]             cnt_q;
  logic                        busy_q, done_q;
  logic                        mul_start;
  logic signed [WW-1:0]        mul_a;
  logic signed [BW-1:0]        mul_b;

  logic signed [bptc_pkg::OutW-1:0] tm, tp;
  logic signed [WW-1:0] prod, f5, f7, f11, pwide;

  logic out_valid_q, out_is_p_q, out_next_p_q;
  logic signed [bptc_pkg::OutW-1:0] out_temp_q, out_press_q;

  assign tm   = temp_q - 32'sd2000;
  assign tp   = temp_q + 32'sd1500;
  assign prod = acc_q;
  assign f5   = (prod <<< 2) + prod;
  assign f7   = (prod <<< 3) - prod;
  assign f11  = (prod <<< 3) + (prod <<< 1) + prod;
  assign pwide = ((prod >>> 21) - off_q) >>> 15;

  assign phase_next = (phase_q >= ratio_q) ? '0 : phase_q + 8'd1;

  always_comb begin
    mul_start = 1'b1;
    mul_a     = '0;
    mul_b     = '0;
    case (cmd_i.op)
      bptc_pkg::OP_MUL_TC: begin
        mul_a = $signed({{(WW-bptc_pkg::CalW){1'b0}}, c6_q});
        mul_b = dt_q;
      end
      bptc_pkg::OP_MUL_OFF: begin
        mul_a = $signed({{(WW-bptc_pkg::CalW){1'b0}}, c4_q});
        mul_b = dt_q;
      end
      bptc_pkg::OP_MUL_SENS: begin
        mul_a = $signed({{(WW-bptc_pkg::CalW){1'b0}}, c3_q});
        mul_b = dt_q;
      end
      bptc_pkg::OP_MUL_DD: begin
        mul_a = {{(WW-BW){dt_q[BW-1]}}, dt_q};
        mul_b = dt_q;
      end
      bptc_pkg::OP_MUL_F: begin
        mul_a = {{(WW-BW){tm[BW-1]}}, tm[BW-1:0]};
        mul_b = tm[BW-1:0];
      end
      bptc_pkg::OP_MUL_F2: begin
        mul_a = {{(WW-BW){tp[BW-1]}}, tp[BW-1:0]};
        mul_b = tp[BW-1:0];
      end
      bptc_pkg::OP_MUL_P: begin
        mul_a = sens_q;
        mul_b = $signed({1'b0, raw_q});
      end
      default: mul_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (mul_start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(BW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // the last step carries the sign bit of the multiplier operand
  always_ff @(posedge clk_i) begin
    if (mul_start) begin
      acc_q <= '0;
      ma_q  <= mul_a;
      mb_q  <= mul_b;
    end else if (busy_q) begin
      if (mb_q[0]) begin
        if (cnt_q == CntW'(BW - 1)) acc_q <= acc_q - ma_q;
        else acc_q <= acc_q + ma_q;
      end
      ma_q <= ma_q <<< 1;
      mb_q <= mb_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) raw_q <= raw_i;
    case (cmd_i.op)
      bptc_pkg::OP_CAPTURE: dt_q <= $signed({1'b0, raw_q}) - $signed({1'b0, c5_q, 8'h00});
      bptc_pkg::OP_WB_T2:   t2_q <= bptc_pkg::OutW'(prod >>> 31);
      bptc_pkg::OP_WB_F: begin
        off2_q  <= f5 >>> 1;
        sens2_q <= f5 >>> 2;
      end
      bptc_pkg::OP_WB_F2: begin
        off2_q  <= off2_q + f7;
        sens2_q <= sens2_q + (f11 >>> 1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0; c2_q <= '0; c3_q <= '0; c4_q <= '0; c5_q <= '0; c6_q <= '0;
      ratio_q <= 8'd1;
      phase_q <= '0;
      temp_q  <= '0;
      off_q   <= '0;
      sens_q  <= '0;
      press_q <= '0;
      out_valid_q  <= 1'b0;
      out_is_p_q   <= 1'b0;
      out_next_p_q <= 1'b0;
      out_temp_q   <= '0;
      out_press_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          bptc_pkg::CFG_C1:    c1_q <= cfg_data_i;
          bptc_pkg::CFG_C2:    c2_q <= cfg_data_i;
          bptc_pkg::CFG_C3:    c3_q <= cfg_data_i;
          bptc_pkg::CFG_C4:    c4_q <= cfg_data_i;
          bptc_pkg::CFG_C5:    c5_q <= cfg_data_i;
          bptc_pkg::CFG_C6:    c6_q <= cfg_data_i;
          bptc_pkg::CFG_RATIO: ratio_q <= cfg_data_i[bptc_pkg::RatioW-1:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        bptc_pkg::OP_WB_T:    temp_q <= 32'sd2000 + bptc_pkg::OutW'(prod >>> 23);
        bptc_pkg::OP_WB_OFF:  off_q <= $signed({{(WW-bptc_pkg::CalW-16){1'b0}}, c2_q, 16'h0})
                                       + (prod >>> 7);
        bptc_pkg::OP_WB_SENS: sens_q <= $signed({{(WW-bptc_pkg::CalW-15){1'b0}}, c1_q, 15'h0})
                                        + (prod >>> 8);
        bptc_pkg::OP_CORR: begin
          temp_q <= temp_q - t2_q;
          off_q  <= off_q - off2_q;
          sens_q <= sens_q - sens2_q;
        end
        bptc_pkg::OP_WB_P: press_q <= pwide[bptc_pkg::OutW-1:0];
        bptc_pkg::OP_FINISH: begin
          out_valid_q  <= 1'b1;
          out_is_p_q   <= (phase_q != '0);
          out_temp_q   <= temp_q;
          out_press_q  <= press_q;
          out_next_p_q <= (phase_next != '0);
          phase_q      <= phase_next;
        end
        default: ;
      endcase
    end
  end

  assign status_o.mul_busy = busy_q;
  assign status_o.mul_done = done_q;
  assign status_o.is_p     = (phase_q != '0);
  assign status_o.t_low    = (temp_q < 32'sd2000);
  assign status_o.t_vlow   = (temp_q < -32'sd1500);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_is_p_o   = out_is_p_q;
  assign out_temp_o   = out_temp_q;
  assign out_press_o  = out_press_q;
  assign out_next_p_o = out_next_p_q;

endmodule

### tb/bptc_tb_pkg.sv
`timescale 1ns / 1ps
// result word type and floor shift used by the barometer testbench to predict results
// depends on bptc_pkg
package bptc_tb_pkg;
  import bptc_pkg::*;

  typedef struct packed {
    logic                    is_pressure;
    logic signed [OutW-1:0]  temperature;
    logic signed [OutW-1:0]  pressure;
    logic                    next_is_pressure;
  } baro_word_t;

  // floor shift, matches arithmetic right shift of a signed 64-bit value
  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction
endpackage

### tb/baro_pressure_temperature_compensation_tb.sv
`timescale 1ns / 1ps
// testbench for the barometer compensation block: predicts each result word
// from its own model of the arithmetic; depends on bptc_pkg, bptc_tb_pkg and the channels
module baro_pressure_temperature_compensation_tb;
  import bptc_pkg::*;
  import bptc_tb_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CalW-1:0] cfg_data_i;

  bptc_in_if in_ch();
  bptc_out_if out_ch();

  baro_pressure_temperature_compensation u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i), .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  // predictor copy of calibration and state
  longint cal_word [6];
  int unsigned samples_per_temp;
  int unsigned phase_cnt;
  longint temp_c, off_term, sens_term, press_c;

  baro_word_t expected_words[$];
  int unsigned fail_count;
  int unsigned send_idle_pct, recv_idle_pct;
  bit recv_hold;

  logic [RawW-1:0] phase_cnt_seq[9] = '{24'd9085466, 24'd8569150, 24'd8569150,
    24'd7000000, 24'd8000000, 24'd6000000, 24'd1000, 24'd8000000, 24'd16777215};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("tb: failure");
    $finish;
  end

  // temperature word: dT, first-order terms, then the low-temperature corrections
  function automatic void compensate_temperature(longint raw);
    longint dt, t, off, sens, t2, f, off2, sens2, f2;
    dt = raw - (cal_word[4] <<< 8);
    t = 2000 + floor_shift(dt * cal_word[5], 23);
    off = (cal_word[1] <<< 16) + floor_shift(cal_word[3] * dt, 7);
    sens = (cal_word[0] <<< 15) + floor_shift(cal_word[2] * dt, 8);
    if (t < 2000) begin
      t2 = floor_shift(dt * dt, 31);
      f = (t - 2000) * (t - 2000);
      off2 = floor_shift(5 * f, 1);
      sens2 = floor_shift(5 * f, 2);
      if (t < -1500) begin
        f2 = (t + 1500) * (t + 1500);
        off2 += 7 * f2;
        sens2 += floor_shift(11 * f2, 1);
      end
      t -= t2;
      off -= off2;
      sens -= sens2;
    end
    temp_c = t;
    off_term = off;
    sens_term = sens;
  endfunction

  function automatic baro_word_t predict_word(logic [RawW-1:0] raw);
    baro_word_t w;
    bit is_p;
    int unsigned nxt;
    longint p;
    is_p = (phase_cnt != 0);
    if (is_p) begin
      p = floor_shift(floor_shift(longint'(raw) * sens_term, 21) - off_term, 15);
      press_c = longint'(int'(p[31:0]));
    end else begin
      compensate_temperature(longint'(raw));
    end
    nxt = phase_cnt + 1;
    if (nxt >= samples_per_temp + 1) nxt = 0;
    phase_cnt = nxt & 8'hff;
    w.is_pressure = is_p;
    w.temperature = temp_c[31:0];
    w.pressure = press_c[31:0];
    w.next_is_pressure = (phase_cnt != 0);
    return w;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CalW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_RATIO) samples_per_temp = val[7:0];
    else cal_word[idx] = val;
    @(posedge clk_i);
  endtask

  // sends one word, idling first with the current sender probability
  task automatic send_sample(logic [RawW-1:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.raw_sample <= raw;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    expected_words.push_back(predict_word(raw));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // receiver: random stalls, plus a long hold while recv_hold is set
  always @(posedge clk_i) begin
    out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    baro_word_t exp_w;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word expected none actual %h", $time,
                 {out_ch.is_pressure, out_ch.temperature, out_ch.pressure,
                  out_ch.next_is_pressure});
        fail_count++;
      end else begin
        exp_w = expected_words.pop_front();
        if (out_ch.is_pressure !== exp_w.is_pressure) begin
          $display("%0t: is_pressure expected %0d actual %0d", $time,
                   exp_w.is_pressure, out_ch.is_pressure);
          fail_count++;
        end
        if (out_ch.temperature !== exp_w.temperature) begin
          $display("%0t: temperature expected %0d actual %0d", $time,
                   exp_w.temperature, out_ch.temperature);
          fail_count++;
        end
        if (out_ch.pressure !== exp_w.pressure) begin
          $display("%0t: pressure expected %0d actual %0d", $time,
                   exp_w.pressure, out_ch.pressure);
          fail_count++;
        end
        if (out_ch.next_is_pressure !== exp_w.next_is_pressure) begin
          $display("%0t: next_is_pressure expected %0d actual %0d", $time,
                   exp_w.next_is_pressure, out_ch.next_is_pressure);
          fail_count++;
        end
      end
    end
  end

  task automatic load_calibration(bit extreme);
    for (int i = 0; i < 6; i++) begin
      if (extreme) write_reg(cfg_idx_e'(i), ($urandom_range(1)) ? 16'hffff : 16'h0000);
      else write_reg(cfg_idx_e'(i), 16'($urandom_range(16'hffff)));
    end
  endtask

  // zero calibration after reset, field extremes, both correction bands
  task automatic test_directed();
    send_sample(24'h123456);
    send_sample(24'h000000);
    send_sample(24'hffffff);
    wait_drained();
    // typical calibration: room, cold, very cold via raw dT
    write_reg(CFG_C1, 16'd40127); write_reg(CFG_C2, 16'd36924);
    write_reg(CFG_C3, 16'd23317); write_reg(CFG_C4, 16'd23282);
    write_reg(CFG_C5, 16'd33464); write_reg(CFG_C6, 16'd28312);
    write_reg(CFG_RATIO, 16'd2);
    wait_drained();
    foreach (phase_cnt_seq[i]) send_sample(phase_cnt_seq[i]);
    wait_drained();
    // maximum calibration and a zero calibration
    for (int i = 0; i < 6; i++) write_reg(cfg_idx_e'(i), 16'hffff);
    send_sample(24'h000000); send_sample(24'hffffff); send_sample(24'hffffff);
    wait_drained();
    for (int i = 0; i < 6; i++) write_reg(cfg_idx_e'(i), 16'h0000);
    send_sample(24'hffffff); send_sample(24'h000001); send_sample(24'h800000);
    wait_drained();
  endtask

  // ratio zero: only temperature words; ratio lowered below the running phase
  task automatic test_ratio_edges();
    write_reg(CFG_RATIO, 16'd0);
    repeat (4) send_sample(24'($urandom_range(24'hffffff)));
    wait_drained();
    write_reg(CFG_RATIO, 16'd255);
    repeat (5) send_sample(24'($urandom_range(24'hffffff)));
    wait_drained();
    write_reg(CFG_RATIO, 16'd1);
    repeat (3) send_sample(24'($urandom_range(24'hffffff)));
    wait_drained();
  endtask

  task automatic run_random(int n);
    int ratio_pick;
    for (int k = 0; k < n; k++) begin
      if (k % 100 == 0) begin
        wait_drained();
        load_calibration($urandom_range(4) == 0);
        ratio_pick = $urandom_range(9);
        write_reg(CFG_RATIO, (ratio_pick == 0) ? 16'd255 : (ratio_pick == 1) ? 16'd0
                  : 16'($urandom_range(1, 8)));
      end
      send_sample(24'($urandom_range(24'hffffff)));
    end
  endtask

  // receiver stuck long while words keep coming, then a sender pause to drain
  task automatic test_backpressure();
    recv_hold = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      begin
        repeat (6) send_sample(24'($urandom_range(24'hffffff)));
        in_ch.valid <= 1'b0;
      end
    join
    wait_drained();
  endtask

  initial begin
    int unsigned timeout;
    fail_count = 0;
    recv_hold = 1'b0;
    send_idle_pct = 18;
    recv_idle_pct = 68;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_C1;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.raw_sample = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < 6; i++) cal_word[i] = 0;
    samples_per_temp = 1;
    phase_cnt = 0;
    temp_c = 0; off_term = 0; sens_term = 0; press_c = 0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_ratio_edges();
    test_backpressure();
    run_random(700);
    send_idle_pct = 68; recv_idle_pct = 18;
    run_random(700);
    send_idle_pct = 0; recv_idle_pct = 0;
    run_random(600);

    in_ch.valid <= 1'b0;
    timeout = 0;
    while (expected_words.size() != 0 && timeout < 100000) begin
      @(posedge clk_i);
      timeout++;
    end
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+hdl
hdl/bptc_pkg.sv
hdl/bptc_in_if.sv
hdl/bptc_out_if.sv
hdl/bptc_ctrl.sv
hdl/bptc_dpath.sv
hdl/baro_pressure_temperature_compensation.sv
tb/bptc_tb_pkg.sv
tb/baro_pressure_temperature_compensation_tb.sv
